FILE: rtl/core/gbf_pkg.sv
package gbf_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_ENTRIES  = 512;
    localparam int VTX_W   = $clog2(MAX_VERTICES);
    localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
    localparam int ENTRY_W = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W  = $clog2(MAX_ENTRIES);
    localparam int TALLY_MAX = 63;

    typedef struct packed {
        logic       mode;
        logic [5:0] neighbor;
    } gbf_item_t;

    typedef struct packed {
        logic [5:0] vertex;
        logic [5:0] bridge_count;
        logic       overflow;
        logic       is_last;
    } gbf_result_t;

    typedef struct packed {
        logic [VTX_W-1:0]   vtx;
        logic [VTX_W-1:0]   par;
        logic               has_par;
        logic [ENTRY_W-1:0] pos;
        logic [ENTRY_W-1:0] lim;
        logic [5:0]         disc;
        logic [5:0]         low;
    } gbf_frame_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROOT,
        ST_LS_A,
        ST_LS_B,
        ST_LS_C,
        ST_SCAN,
        ST_NB,
        ST_BACK,
        ST_POP,
        ST_POP2,
        ST_BU,
        ST_BC,
        ST_OUT,
        ST_FIN
    } gbf_state_t;

endpackage

FILE: rtl/core/gbf_ram.sv
module gbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/graph_bridge_finder.sv
// Bridge counter for an undirected graph of up to 64 vertices. Each start beat carries
// either a neighbour entry for the vertex being loaded or the close of its list; such
// beats are taken one per cycle while busy is low. Closing the list of the last vertex
// starts a depth-first walk, during which busy is high: each root is checked, each vertex
// discovered has its list bounds fetched and is later retired, each adjacency entry is
// scanned, one reaching a visited vertex also reads its discovery time, and each bridge
// found bumps the tallies of both its ends, all set by the single sequencer and its
// memories of one read and one write port each. One result beat per vertex follows,
// one per cycle, on result with result_valid high for exactly one cycle; busy falls in
// the cycle after the last beat; the receiver cannot stall them, so it must take every beat.
module graph_bridge_finder import gbf_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  gbf_item_t   item,
    output logic        result_valid,
    output gbf_result_t result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    gbf_state_t state_reg, state_next;
    logic [6:0]         vc_reg;
    logic [CNT_W-1:0]   lv_reg, lv_next;
    logic [ENTRY_W-1:0] ec_reg, ec_next;
    logic               ovf_reg, ovf_next;
    logic [CNT_W-1:0]   time_reg, time_next;
    logic [CNT_W-1:0]   root_reg, root_next;
    logic [CNT_W-1:0]   sp_reg, sp_next;
    logic [CNT_W-1:0]   oidx_reg, oidx_next;
    logic [VTX_W-1:0]   ridx_reg, ridx_next;
    logic               pend_reg, pend_next;
    logic [VTX_W-1:0]   child_reg, child_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [MAX_VERTICES-1:0] tval_reg, tval_next;
    gbf_frame_t frame_reg, frame_next;

    logic [CNT_W-1:0] n;
    logic [VTX_W-1:0] to;
    gbf_frame_t       pf;
    logic [5:0]       tally_cur;
    logic             load_ok;

    logic adj_we;  logic [ADDR_W-1:0] adj_waddr, adj_raddr; logic [5:0] adj_rdata;
    logic lst_we;  logic [VTX_W-1:0] lst_waddr, lst_raddr; logic [ENTRY_W-1:0] lst_rdata;
    logic disc_we; logic [VTX_W-1:0] disc_waddr, disc_raddr; logic [5:0] disc_rdata;
    logic tal_we;  logic [VTX_W-1:0] tal_waddr, tal_raddr;
    logic [5:0] tal_wdata, tal_rdata;
    logic stk_we;  logic [VTX_W-1:0] stk_waddr, stk_raddr;
    logic [$bits(gbf_frame_t)-1:0] stk_rdata;

    assign cfg_ready = 1'b1;
    assign busy = (state_reg != ST_IDLE);
    assign to = adj_rdata;
    assign pf = gbf_frame_t'(stk_rdata);

    always_comb
    begin
        if (vc_reg == 7'd0)
        begin
            n = CNT_W'(1);
        end
        else if (vc_reg > 7'(MAX_VERTICES))
        begin
            n = CNT_W'(MAX_VERTICES);
        end
        else
        begin
            n = CNT_W'(vc_reg);
        end
    end

    assign load_ok = (lv_reg < n) && ({1'b0, item.neighbor} < n)
                     && (ec_reg < ENTRY_W'(MAX_ENTRIES));
    assign tally_cur = tval_reg[tal_waddr] ? tal_rdata : 6'd0;
    assign tal_wdata = (tally_cur == 6'(TALLY_MAX)) ? tally_cur : tally_cur + 6'd1;

    always_comb
    begin
        state_next   = state_reg;
        lv_next      = lv_reg;
        ec_next      = ec_reg;
        ovf_next     = ovf_reg;
        time_next    = time_reg;
        root_next    = root_reg;
        sp_next      = sp_reg;
        oidx_next    = oidx_reg;
        ridx_next    = ridx_reg;
        pend_next    = 1'b0;
        child_next   = child_reg;
        visited_next = visited_reg;
        tval_next    = tval_reg;
        frame_next   = frame_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (!item.mode)
                    begin
                        if (load_ok)
                        begin
                            ec_next = ec_reg + ENTRY_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else if ((lv_reg + CNT_W'(1)) < n)
                    begin
                        lv_next = lv_reg + CNT_W'(1);
                    end
                    else
                    begin
                        visited_next = '0;
                        tval_next    = '0;
                        time_next    = '0;
                        root_next    = '0;
                        sp_next      = '0;
                        state_next   = ST_ROOT;
                    end
                end
            end
            ST_ROOT:
            begin
                if (root_reg == n)
                begin
                    oidx_next  = '0;
                    state_next = ST_OUT;
                end
                else if (visited_reg[root_reg[VTX_W-1:0]])
                begin
                    root_next = root_reg + CNT_W'(1);
                end
                else
                begin
                    visited_next[root_reg[VTX_W-1:0]] = 1'b1;
                    frame_next.vtx     = root_reg[VTX_W-1:0];
                    frame_next.par     = '0;
                    frame_next.has_par = 1'b0;
                    frame_next.pos     = '0;
                    frame_next.lim     = '0;
                    frame_next.disc    = time_reg[5:0];
                    frame_next.low     = time_reg[5:0];
                    time_next  = time_reg + CNT_W'(1);
                    state_next = ST_LS_A;
                end
            end
            ST_LS_A:
            begin
                state_next = ST_LS_B;
            end
            ST_LS_B:
            begin
                frame_next.pos = (frame_reg.vtx == '0) ? '0 : lst_rdata;
                state_next = ST_LS_C;
            end
            ST_LS_C:
            begin
                frame_next.lim = lst_rdata;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (frame_reg.pos < frame_reg.lim)
                begin
                    frame_next.pos = frame_reg.pos + ENTRY_W'(1);
                    state_next = ST_NB;
                end
                else
                begin
                    state_next = ST_POP;
                end
            end
            ST_NB:
            begin
                if (({1'b0, to} >= n) || (frame_reg.has_par && to == frame_reg.par))
                begin
                    state_next = ST_SCAN;
                end
                else if (visited_reg[to])
                begin
                    state_next = ST_BACK;
                end
                else
                begin
                    visited_next[to] = 1'b1;
                    sp_next = sp_reg + CNT_W'(1);
                    frame_next.vtx     = to;
                    frame_next.par     = frame_reg.vtx;
                    frame_next.has_par = 1'b1;
                    frame_next.pos     = '0;
                    frame_next.lim     = '0;
                    frame_next.disc    = time_reg[5:0];
                    frame_next.low     = time_reg[5:0];
                    time_next  = time_reg + CNT_W'(1);
                    state_next = ST_LS_A;
                end
            end
            ST_BACK:
            begin
                if (disc_rdata < frame_reg.low)
                begin
                    frame_next.low = disc_rdata;
                end
                state_next = ST_SCAN;
            end
            ST_POP:
            begin
                if (sp_reg == '0)
                begin
                    root_next  = root_reg + CNT_W'(1);
                    state_next = ST_ROOT;
                end
                else
                begin
                    state_next = ST_POP2;
                end
            end
            ST_POP2:
            begin
                child_next = frame_reg.vtx;
                frame_next = pf;
                if (frame_reg.low < pf.low)
                begin
                    frame_next.low = frame_reg.low;
                end
                sp_next = sp_reg - CNT_W'(1);
                state_next = (frame_reg.low > pf.disc) ? ST_BU : ST_SCAN;
            end
            ST_BU:
            begin
                tval_next[frame_reg.vtx] = 1'b1;
                state_next = ST_BC;
            end
            ST_BC:
            begin
                tval_next[child_reg] = 1'b1;
                state_next = ST_SCAN;
            end
            ST_OUT:
            begin
                pend_next = 1'b1;
                ridx_next = oidx_reg[VTX_W-1:0];
                if (oidx_reg == n - CNT_W'(1))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    oidx_next = oidx_reg + CNT_W'(1);
                end
            end
            ST_FIN:
            begin
                lv_next    = '0;
                ec_next    = '0;
                ovf_next   = 1'b0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        adj_we     = 1'b0;
        adj_waddr  = ec_reg[ADDR_W-1:0];
        adj_raddr  = frame_reg.pos[ADDR_W-1:0];
        lst_we     = 1'b0;
        lst_waddr  = lv_reg[VTX_W-1:0];
        lst_raddr  = frame_reg.vtx;
        disc_we    = 1'b0;
        disc_waddr = to;
        disc_raddr = to;
        tal_we     = 1'b0;
        tal_waddr  = frame_reg.vtx;
        tal_raddr  = frame_reg.vtx;
        stk_we     = 1'b0;
        stk_waddr  = sp_reg[VTX_W-1:0];
        stk_raddr  = sp_reg[VTX_W-1:0] - VTX_W'(1);
        case (state_reg)
            ST_IDLE:
            begin
                adj_we = start && !item.mode && load_ok;
                lst_we = start && item.mode;
            end
            ST_ROOT:
            begin
                disc_waddr = root_reg[VTX_W-1:0];
                disc_we = (root_reg != n) && !visited_reg[root_reg[VTX_W-1:0]];
            end
            ST_LS_A:
            begin
                lst_raddr = frame_reg.vtx - VTX_W'(1);
            end
            ST_NB:
            begin
                disc_we = ({1'b0, to} < n) && !(frame_reg.has_par && to == frame_reg.par)
                          && !visited_reg[to];
                stk_we = disc_we;
            end
            ST_POP2:
            begin
                tal_raddr = pf.vtx;
            end
            ST_BU:
            begin
                tal_we    = 1'b1;
                tal_raddr = child_reg;
            end
            ST_BC:
            begin
                tal_we    = 1'b1;
                tal_waddr = child_reg;
            end
            ST_OUT:
            begin
                tal_raddr = oidx_reg[VTX_W-1:0];
            end
            default:
            begin
                adj_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            vc_reg      <= 7'(MAX_VERTICES);
            lv_reg      <= '0;
            ec_reg      <= '0;
            ovf_reg     <= 1'b0;
            time_reg    <= '0;
            root_reg    <= '0;
            sp_reg      <= '0;
            oidx_reg    <= '0;
            pend_reg    <= 1'b0;
            visited_reg <= '0;
            tval_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                vc_reg <= cfg_data;
            end
            lv_reg      <= lv_next;
            ec_reg      <= ec_next;
            ovf_reg     <= ovf_next;
            time_reg    <= time_next;
            root_reg    <= root_next;
            sp_reg      <= sp_next;
            oidx_reg    <= oidx_next;
            pend_reg    <= pend_next;
            visited_reg <= visited_next;
            tval_reg    <= tval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg  <= ridx_next;
        child_reg <= child_next;
        frame_reg <= frame_next;
    end

    assign result_valid        = pend_reg;
    assign result.vertex       = ridx_reg;
    assign result.bridge_count = tval_reg[ridx_reg] ? tal_rdata : 6'd0;
    assign result.overflow     = ovf_reg;
    assign result.is_last      = ({1'b0, ridx_reg} == n - CNT_W'(1));

    gbf_ram #(.WIDTH(6), .DEPTH(MAX_ENTRIES)) u_adj (
        .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(item.neighbor),
        .raddr(adj_raddr), .rdata(adj_rdata)
    );

    gbf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_VERTICES)) u_lst (
        .clk(clk), .we(lst_we), .waddr(lst_waddr), .wdata(ec_reg),
        .raddr(lst_raddr), .rdata(lst_rdata)
    );

    gbf_ram #(.WIDTH(6), .DEPTH(MAX_VERTICES)) u_disc (
        .clk(clk), .we(disc_we), .waddr(disc_waddr), .wdata(time_reg[5:0]),
        .raddr(disc_raddr), .rdata(disc_rdata)
    );

    gbf_ram #(.WIDTH(6), .DEPTH(MAX_VERTICES)) u_tally (
        .clk(clk), .we(tal_we), .waddr(tal_waddr), .wdata(tal_wdata),
        .raddr(tal_raddr), .rdata(tal_rdata)
    );

    gbf_ram #(.WIDTH($bits(gbf_frame_t)), .DEPTH(MAX_VERTICES)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(frame_reg),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    // A result beat only ever appears while the walk or the readout holds the block.
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy) else $error("result beat while idle");

    // After the final vertex the block returns to loading at once.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.is_last) |=> (!result_valid && !busy))
        else $error("block not idle after last result");

    // The stack never holds more frames than there are vertices.
    a_stack_depth: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg < CNT_W'(MAX_VERTICES)) else $error("walk stack overrun");

    // Each vertex is discovered once, so the clock never passes the vertex count.
    a_time_bound: assert property (@(posedge clk) disable iff (!rst_n)
        time_reg <= CNT_W'(MAX_VERTICES)) else $error("discovery time overrun");

endmodule
